[src/asacs_pkg.sv]
`timescale 1ns / 1ps
// Package for the arcsine/arccosine unit: word types, controller commands,
// status and fixed-point constants. No dependencies.
package asacs_pkg;

	localparam int FRAC_BITS = 30;
	localparam int MAX_TERMS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int STOP_W = 31;
	localparam logic [DATA_W-1:0] HALF_PI = 32'h6487_ED51;
	localparam logic [DATA_W-1:0] ONE_MAG = 32'h4000_0000;
	localparam logic [DATA_W-1:0] HALF_MAG = 32'h2000_0000;

	typedef struct packed {
		logic action;
		logic signed [31:0] x_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic invalid;
	} out_t;

	typedef enum logic [1:0] {
		MUL_MM = 2'd0,
		MUL_XX = 2'd1,
		MUL_TX = 2'd2,
		MUL_II = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		mul_sel_t mul_sel;
		logic sqrt_init;
		logic sqrt_step;
		logic ser_small;
		logic ser_root;
		logic take_x2;
		logic div_init;
		logic div_step;
		logic acc;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic big;
		logic cnt_last;
		logic more;
	} sts_t;

endpackage

[src/asacs_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the arcsine/arccosine unit.
// Depends on asacs_pkg for the command and status structs.
module asacs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  asacs_pkg::sts_t sts,
	output asacs_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_SQ   = 4'd2;
	localparam logic [3:0] S_RT   = 4'd3;
	localparam logic [3:0] S_RTD  = 4'd4;
	localparam logic [3:0] S_X2   = 4'd5;
	localparam logic [3:0] S_X2T  = 4'd6;
	localparam logic [3:0] S_LOOP = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_DI   = 4'd9;
	localparam logic [3:0] S_DV   = 4'd10;
	localparam logic [3:0] S_ACC  = 4'd11;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = asacs_pkg::MUL_MM;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.invalid) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else if (sts.big) begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = asacs_pkg::MUL_MM;
					state_d = S_SQ;
				end else begin
					cmd.ser_small = 1'b1;
					state_d = S_X2;
				end
			end
			S_SQ: begin
				cmd.sqrt_init = 1'b1;
				state_d = S_RT;
			end
			S_RT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.cnt_last) state_d = S_RTD;
			end
			S_RTD: begin
				cmd.ser_root = 1'b1;
				state_d = S_X2;
			end
			S_X2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = asacs_pkg::MUL_XX;
				state_d = S_X2T;
			end
			S_X2T: begin
				cmd.take_x2 = 1'b1;
				state_d = S_LOOP;
			end
			S_LOOP: begin
				if (sts.more) begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = asacs_pkg::MUL_TX;
					state_d = S_M2;
				end else begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_M2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = asacs_pkg::MUL_II;
				state_d = S_DI;
			end
			S_DI: begin
				cmd.div_init = 1'b1;
				state_d = S_DV;
			end
			S_DV: begin
				cmd.div_step = 1'b1;
				if (sts.cnt_last) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_LOOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/asacs_dp.sv]
`timescale 1ns / 1ps
// Datapath of the arcsine/arccosine unit: shared multiplier, square-root and
// division recurrences, series accumulator and output rounding.
// Depends on asacs_pkg.
module asacs_dp #(
	parameter int MAX_TERMS = asacs_pkg::MAX_TERMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  asacs_pkg::in_t item,
	input  logic [asacs_pkg::STOP_W-1:0] term_stop,
	input  asacs_pkg::cmd_t cmd,
	output asacs_pkg::sts_t sts,
	output logic done,
	output asacs_pkg::out_t result
);

	localparam int I_W = $clog2(2 * MAX_TERMS + 2);
	localparam int C_W = 2 * I_W;
	localparam int N_W = $clog2(MAX_TERMS + 1);
	localparam int P_W = 32 + C_W;
	localparam int F = asacs_pkg::FRAC_BITS;

	logic neg_q, act_q, inv_q, big_q;
	logic [31:0] m_q, x_q, x2_q, t_q, q_q;
	logic [32:0] s_q;
	logic [63:0] prod_q;
	logic [P_W-1:0] p_q;
	logic [C_W:0] drem_q;
	logic [61:0] rad_q;
	logic [34:0] srem_q;
	logic [30:0] root_q;
	logic [4:0] cnt_q;
	logic [I_W-1:0] i_q;
	logic [N_W-1:0] n_q;
	logic done_q;
	asacs_pkg::out_t res_q;

	logic [32:0] raw_mag;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [C_W-1:0] ii, cdiv;
	logic [I_W:0] i_p1, i_p2;
	logic [34:0] s_trial, s_shift;
	logic [C_W:0] d_shift;
	logic signed [34:0] a_val, ang;
	logic [34:0] amag, omag;

	assign raw_mag = item.x_value[31] ? (33'h1_0000_0000 - {1'b0, item.x_value})
		: {1'b0, item.x_value};

	assign ii = C_W'(i_q) * C_W'(i_q);
	assign i_p1 = {1'b0, i_q} + 1'b1;
	assign i_p2 = {1'b0, i_q} + 2'd2;
	assign cdiv = C_W'(i_p1) * C_W'(i_p2);

	always_comb begin
		case (cmd.mul_sel)
			asacs_pkg::MUL_MM: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			asacs_pkg::MUL_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			asacs_pkg::MUL_TX: begin
				mul_a = t_q;
				mul_b = x2_q;
			end
			default: begin
				mul_a = prod_q[F+31:F];
				mul_b = 32'(ii);
			end
		endcase
	end

	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	assign s_shift = {srem_q[32:0], rad_q[61:60]};
	assign s_trial = {2'b0, root_q, 2'b01};
	assign d_shift = {drem_q[C_W-1:0], p_q[31]};

	assign sts.invalid = inv_q;
	assign sts.big = big_q;
	assign sts.cnt_last = (cnt_q == 5'd31) || (cmd.sqrt_step && cnt_q == 5'd30);
	assign sts.more = (n_q < N_W'(MAX_TERMS)) && (t_q > {1'b0, term_stop});

	always_comb begin
		a_val = big_q ? (35'(asacs_pkg::HALF_PI) - 35'(s_q)) : 35'(s_q);
		ang = neg_q ? -a_val : a_val;
		if (act_q) ang = 35'(asacs_pkg::HALF_PI) - ang;
		amag = ang[34] ? 35'(-ang) : 35'(ang);
		omag = (amag + 35'd1) >> 1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= item.x_value[31];
			act_q <= item.action;
			inv_q <= raw_mag > 33'(asacs_pkg::ONE_MAG);
			big_q <= raw_mag > 33'(asacs_pkg::HALF_MAG);
			m_q <= raw_mag[31:0];
		end
		if (cmd.mul_en) begin
			if (cmd.mul_sel == asacs_pkg::MUL_II) begin
				p_q <= mul_p[P_W-1:0];
			end else begin
				prod_q <= mul_p;
			end
		end
		if (cmd.sqrt_init) begin
			rad_q <= {(asacs_pkg::ONE_MAG - prod_q[F+31:F]), 30'b0};
			srem_q <= '0;
			root_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[59:0], 2'b00};
			cnt_q <= cnt_q + 5'd1;
			if (s_shift >= s_trial) begin
				srem_q <= s_shift - s_trial;
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				srem_q <= s_shift;
				root_q <= {root_q[29:0], 1'b0};
			end
		end
		if (cmd.ser_small || cmd.ser_root) begin
			x_q <= cmd.ser_root ? {1'b0, root_q} : m_q;
			t_q <= cmd.ser_root ? {1'b0, root_q} : m_q;
			s_q <= cmd.ser_root ? {2'b0, root_q} : {1'b0, m_q};
			i_q <= I_W'(1);
			n_q <= N_W'(1);
		end
		if (cmd.take_x2) x2_q <= prod_q[F+31:F];
		if (cmd.div_init) begin
			drem_q <= {1'b0, p_q[P_W-1:32]};
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			p_q <= {p_q[P_W-2:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (d_shift >= {1'b0, cdiv}) begin
				drem_q <= d_shift - {1'b0, cdiv};
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				drem_q <= d_shift;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
		if (cmd.acc) begin
			t_q <= q_q;
			s_q <= s_q + {1'b0, q_q};
			i_q <= i_q + I_W'(2);
			n_q <= n_q + N_W'(1);
		end
		if (cmd.fin) begin
			if (inv_q) begin
				res_q.angle <= '0;
				res_q.invalid <= 1'b1;
			end else begin
				res_q.invalid <= 1'b0;
				if (ang[34]) begin
					res_q.angle <= (omag > 35'h0_8000_0000) ? 32'h8000_0000
						: 32'(35'h1_0000_0000 - omag);
				end else begin
					res_q.angle <= (omag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
						: omag[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

[src/arcsine_arccosine_series.sv]
`timescale 1ns / 1ps
// Invalid arguments finish without the series; large |x| adds a bitwise square root
// (one digit per cycle) ahead of the series.
// The 32-step divider of each term update sets most of the cost.
// One word at a time: busy stays high until the result strobe is issued.
// Reset clears the controller, the strobe, and term_stop to one.
module arcsine_arccosine_series #(
	parameter int MAX_TERMS = asacs_pkg::MAX_TERMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  asacs_pkg::in_t item,
	output logic done,
	output asacs_pkg::out_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [asacs_pkg::STOP_W-1:0] term_stop_q;
	asacs_pkg::cmd_t cmd;
	asacs_pkg::sts_t sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {1'b0, term_stop_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_stop_q <= 31'd1;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			term_stop_q <= pwdata[30:0];
		end
	end

	asacs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sts(sts),
		.cmd(cmd)
	);

	asacs_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.term_stop(term_stop_q),
		.cmd(cmd),
		.sts(sts),
		.done(done),
		.result(result)
	);

endmodule

[src/asacs_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the arcsine/arccosine unit, bound to the top level.
// Depends on asacs_pkg for the word types.
module asacs_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input asacs_pkg::out_t result,
	input logic pready
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without work");

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.invalid |-> result.angle == 32'sd0)
		else $error("invalid result with nonzero angle");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind arcsine_arccosine_series asacs_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result),
	.pready(pready)
);

[dv/tb_arcsine_arccosine_series.sv]
`timescale 1ns / 1ps
// Self-checking testbench for arcsine_arccosine_series: directed and random words
// are checked against a bit-exact fixed-point predictor across several term_stop settings.
// Depends on asacs_pkg and the arcsine_arccosine_series RTL.
module tb_arcsine_arccosine_series;

	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
	localparam int SERIES_MAX = 16;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam logic [2:0] ADDR_TERM_STOP = 3'd0;
	localparam logic ACT_ASIN = 1'b0;
	localparam logic ACT_ACOS = 1'b1;

	typedef struct {
		logic act;
		logic [31:0] x;
		bit known;
		logic [31:0] angle;
		logic invalid;
	} vector_t;

	logic clk, arst_n, start, busy, done, psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	asacs_pkg::in_t item;
	asacs_pkg::out_t result;

	asacs_pkg::out_t angle_q[$];
	logic [63:0] stop_level;
	int errors;
	int cycles;

	arcsine_arccosine_series i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[93:30];
	endfunction

	function automatic logic [63:0] frac_root(logic [63:0] v);
		logic [127:0] target, c;
		logic [63:0] r;
		target = {64'b0, v} << 30;
		r = 0;
		for (int b = 30; b >= 0; b--) begin
			c = {64'b0, r | (64'd1 << b)};
			if (c * c <= target) r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] series_sum(logic [63:0] x);
		logic [63:0] x2, t, s, i;
		logic [127:0] q;
		int n;
		x2 = frac_mul(x, x);
		t = x;
		s = x;
		i = 1;
		n = 1;
		while (n < SERIES_MAX && t > stop_level) begin
			q = ({64'b0, frac_mul(t, x2)} * {64'b0, i * i}) / {64'b0, (i + 1) * (i + 2)};
			t = q[63:0];
			s = s + t;
			i = i + 2;
			n++;
		end
		return s;
	endfunction

	function automatic asacs_pkg::out_t angle_predict(logic act, logic [31:0] x);
		logic [63:0] mag, a, half_pi, omag;
		logic signed [63:0] ang;
		asacs_pkg::out_t res;
		mag = x[31] ? (64'h1_0000_0000 - {32'b0, x}) : {32'b0, x};
		res.angle = '0;
		res.invalid = 1'b1;
		if (mag > ONE_Q30) return res;
		half_pi = (PI_Q62 + 64'h1_0000_0000) >> 33;
		if (mag <= (ONE_Q30 >> 1)) a = series_sum(mag);
		else a = half_pi - series_sum(frac_root(ONE_Q30 - frac_mul(mag, mag)));
		ang = x[31] ? -$signed(a) : $signed(a);
		if (act == ACT_ACOS) ang = $signed(half_pi) - ang;
		omag = (ang < 0) ? -ang : ang;
		omag = (omag + 1) >> 1;
		if (ang < 0) begin
			if (omag > 64'h8000_0000) omag = 64'h8000_0000;
			omag = 64'h1_0000_0000 - omag;
		end else if (omag > 64'h7FFF_FFFF) begin
			omag = 64'h7FFF_FFFF;
		end
		res.angle = omag[31:0];
		res.invalid = 1'b0;
		return res;
	endfunction

	always @(posedge clk) begin
		asacs_pkg::out_t want;
		if (arst_n && done) begin
			if (angle_q.size() == 0) begin
				$error("result word with nothing expected: angle %h invalid %b",
					result.angle, result.invalid);
				errors++;
			end else begin
				want = angle_q.pop_front();
				if (result.angle !== want.angle) begin
					$error("angle: expected %h, actual %h", want.angle, result.angle);
					errors++;
				end
				if (result.invalid !== want.invalid) begin
					$error("invalid: expected %b, actual %b", want.invalid, result.invalid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_word(logic act, logic [31:0] x, asacs_pkg::out_t want);
		@(negedge clk);
		start = 1'b1;
		item.action = act;
		item.x_value = x;
		do @(posedge clk); while (busy);
		angle_q.push_back(want);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		while (angle_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_term_stop(logic [31:0] value);
		drain();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_TERM_STOP;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		stop_level = {33'b0, value[30:0]};
	endtask

	function automatic logic [31:0] random_x();
		int pick;
		logic [31:0] v;
		pick = $urandom_range(0, 9);
		if (pick < 4) v = $urandom_range(0, 32'h2000_0000);
		else if (pick < 8) v = $urandom_range(32'h2000_0000, 32'h4000_0000);
		else return $urandom;
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	initial begin
		vector_t dir[$];
		vector_t v;
		logic [31:0] stops[5];
		asacs_pkg::out_t bad;
		logic act;
		logic [31:0] x;
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_TERM_STOP;
		pwdata = '0;
		stop_level = 1;
		bad.angle = '0;
		bad.invalid = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir = '{
			'{ACT_ASIN, 32'h0000_0000, 0, 0, 0}, '{ACT_ACOS, 32'h0000_0000, 0, 0, 0},
			'{ACT_ASIN, 32'h4000_0000, 0, 0, 0}, '{ACT_ACOS, 32'h4000_0000, 0, 0, 0},
			'{ACT_ASIN, 32'hC000_0000, 0, 0, 0}, '{ACT_ACOS, 32'hC000_0000, 0, 0, 0},
			'{ACT_ASIN, 32'h2000_0000, 0, 0, 0}, '{ACT_ACOS, 32'hE000_0000, 0, 0, 0},
			'{ACT_ASIN, 32'h2000_0001, 0, 0, 0}, '{ACT_ACOS, 32'hDFFF_FFFF, 0, 0, 0},
			'{ACT_ASIN, 32'h0000_0001, 0, 0, 0}, '{ACT_ACOS, 32'hFFFF_FFFF, 0, 0, 0},
			'{ACT_ASIN, 32'h3FFF_FFFF, 0, 0, 0}, '{ACT_ACOS, 32'hC000_0001, 0, 0, 0},
			'{ACT_ASIN, 32'h4000_0001, 1, 0, 1}, '{ACT_ACOS, 32'hBFFF_FFFF, 1, 0, 1},
			'{ACT_ASIN, 32'h7FFF_FFFF, 1, 0, 1}, '{ACT_ACOS, 32'h8000_0000, 1, 0, 1}
		};
		foreach (dir[k]) begin
			v = dir[k];
			if (v.known) send_word(v.act, v.x, '{angle: v.angle, invalid: v.invalid});
			else send_word(v.act, v.x, angle_predict(v.act, v.x));
			if (k % 3 == 0) idle_gap();
		end

		stops = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'h4000_0000, 32'd1};
		foreach (stops[p]) begin
			write_term_stop(stops[p]);
			repeat (160) begin
				act = $urandom_range(0, 1);
				x = random_x();
				if (x == 32'h8000_0000 || ($signed(x) > 32'sh4000_0000)
						|| ($signed(x) < -32'sh4000_0000))
					send_word(act, x, bad);
				else
					send_word(act, x, angle_predict(act, x));
				if ($urandom_range(0, 2) != 0) idle_gap();
				if (p == 2 && $urandom_range(0, 59) == 0) drain();
			end
		end

		drain();
		repeat (700) @(posedge clk);
		if (errors == 0 && angle_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
